FILE: src/chst_pkg.sv
// ----------------------------------------------------------------------------
// chst_pkg
// Shared types, codes and defaults of the chained hash set table.
// ----------------------------------------------------------------------------
package chst_pkg;

	localparam int MAX_BUCKETS_DEF = 32;
	localparam int CHAIN_DEPTH_DEF = 8;
	localparam int KEY_W           = 31;
	localparam int BCNT_W          = 6;
	localparam int REM_W           = 6;
	localparam int BIDX_W          = 5;

	localparam logic [BCNT_W-1:0] BUCKET_COUNT_RESET = 6'd21;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_SEARCH = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [1:0]       func;
		logic [KEY_W-1:0] key;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [BIDX_W-1:0] bucket_index;
		logic [KEY_W-1:0]  entry_key;
		logic              last;
	} rsp_item_t;

	typedef struct packed {
		logic       take;
		logic       load_fill;
		logic       idx_inc;
		logic       rd_cur;
		logic       rd_next;
		logic       wr_ins;
		logic       wr_shift;
		logic       fill_inc;
		logic       fill_dec;
		logic       emit;
		logic [1:0] emit_status;
		logic       emit_entry;
		logic       emit_last_idx;
	} chst_cmd_t;

	typedef struct packed {
		logic [1:0] in_func;
		logic [1:0] func;
		logic       div_done;
		logic       full;
		logic       empty;
		logic       idx_last;
		logic       hit;
		logic       out_free;
	} chst_sts_t;

endpackage

FILE: src/chst_mod.sv
// ----------------------------------------------------------------------------
// chst_mod
// Iterative key modulo bucket count, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module chst_mod
	import chst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  dividend,
	input  logic [REM_W-1:0]  modulus,
	output logic              done,
	output logic [REM_W-1:0]  rem
);

	localparam int DIGIT = 4;
	localparam int STEPS = (KEY_W + DIGIT - 1) / DIGIT;
	localparam int PAD_W = STEPS * DIGIT;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PAD_W-1:0] sh_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] rem_nxt;

	always_comb begin
		logic [REM_W:0]   t7;
		logic [REM_W-1:0] t;
		t = rem_q;
		for (int j = 0; j < DIGIT; j++) begin
			t7 = {t, sh_q[PAD_W-1-j]};
			if (t7 >= {1'b0, modulus}) begin
				t7 = t7 - {1'b0, modulus};
			end
			t = t7[REM_W-1:0];
		end
		rem_nxt = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= PAD_W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << DIGIT;
			rem_q <= rem_nxt;
		end
	end

	assign done = busy_q && (cnt_q == CNT_W'(STEPS - 1));
	assign rem  = rem_q;

endmodule

FILE: src/chst_dpath.sv
// ----------------------------------------------------------------------------
// chst_dpath
// Datapath: bucket count, hashing, fill counts, key memory and result register.
// ----------------------------------------------------------------------------
module chst_dpath
	import chst_pkg::*;
#(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
	parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [BCNT_W-1:0] cfg_wr_data,
	input  cmd_item_t         cmd,
	output rsp_item_t         rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  chst_cmd_t         ctl,
	output chst_sts_t         sts
);

	localparam int TOTAL = MAX_BUCKETS * CHAIN_DEPTH;
	localparam int AW    = $clog2(TOTAL);
	localparam int BW    = $clog2(MAX_BUCKETS);
	localparam int FW    = $clog2(CHAIN_DEPTH + 1);

	logic [BCNT_W-1:0] bcnt_q;
	logic [REM_W-1:0]  modulus;
	logic [REM_W-1:0]  rem;
	logic              div_done;
	logic [1:0]        func_q;
	logic [KEY_W-1:0]  key_q;
	logic [FW-1:0]     fill_q [MAX_BUCKETS];
	logic [FW-1:0]     cur_fill_q;
	logic [FW-1:0]     idx_q;
	logic [FW-1:0]     idx_p1;
	logic [BW-1:0]     bkt;
	logic [AW-1:0]     base;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [KEY_W-1:0]  wdata;
	logic              we;
	logic              re;
	logic [KEY_W-1:0]  mem [TOTAL];
	logic [KEY_W-1:0]  rdata_q;
	logic              idx_last;
	rsp_item_t         rsp_q;
	logic              rsp_valid_q;
	logic              out_free;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= BUCKET_COUNT_RESET;
		end else if (cfg_wr_en) begin
			bcnt_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (bcnt_q == '0) begin
			modulus = REM_W'(1);
		end else if (int'(bcnt_q) > MAX_BUCKETS) begin
			modulus = REM_W'(MAX_BUCKETS);
		end else begin
			modulus = bcnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			func_q <= cmd.func;
			key_q  <= cmd.key;
		end
	end

	chst_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.take),
		.dividend (cmd.key),
		.modulus  (modulus),
		.done     (div_done),
		.rem      (rem)
	);

	assign bkt    = BW'(rem);
	assign base   = AW'(bkt) * AW'(CHAIN_DEPTH);
	assign idx_p1 = idx_q + 1'b1;

	// fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BUCKETS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (ctl.fill_inc) begin
			fill_q[bkt] <= cur_fill_q + 1'b1;
		end else if (ctl.fill_dec) begin
			fill_q[bkt] <= cur_fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_fill) begin
			cur_fill_q <= fill_q[bkt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.take || ctl.load_fill) begin
			idx_q <= '0;
		end else if (ctl.idx_inc) begin
			idx_q <= idx_p1;
		end
	end

	// key memory
	assign re    = ctl.rd_cur || ctl.rd_next;
	assign raddr = base + (ctl.rd_next ? AW'(idx_p1) : AW'(idx_q));
	assign we    = ctl.wr_ins || ctl.wr_shift;
	assign waddr = base + (ctl.wr_ins ? AW'(cur_fill_q) : AW'(idx_q));
	assign wdata = ctl.wr_ins ? key_q : rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign idx_last = (idx_p1 == cur_fill_q);

	// result register
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			rsp_q.status       <= ctl.emit_status;
			rsp_q.bucket_index <= BIDX_W'(rem);
			rsp_q.entry_key    <= ctl.emit_entry ? rdata_q : '0;
			rsp_q.last         <= ctl.emit_last_idx ? idx_last : 1'b1;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign sts.in_func  = cmd.func;
	assign sts.func     = func_q;
	assign sts.div_done = div_done;
	assign sts.full     = (cur_fill_q == FW'(CHAIN_DEPTH));
	assign sts.empty    = (cur_fill_q == '0);
	assign sts.idx_last = idx_last;
	assign sts.hit      = (rdata_q == key_q);
	assign sts.out_free = out_free;

endmodule

FILE: src/chst_ctrl.sv
// ----------------------------------------------------------------------------
// chst_ctrl
// Controller: sequences hashing, chain walk, shift on remove and listing.
// ----------------------------------------------------------------------------
module chst_ctrl
	import chst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  chst_sts_t sts,
	output chst_cmd_t ctl
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DIV    = 4'd1;
	localparam logic [3:0] S_FILL   = 4'd2;
	localparam logic [3:0] S_DISP   = 4'd3;
	localparam logic [3:0] S_INS    = 4'd4;
	localparam logic [3:0] S_RD     = 4'd5;
	localparam logic [3:0] S_CMP    = 4'd6;
	localparam logic [3:0] S_NOTF   = 4'd7;
	localparam logic [3:0] S_SH_CHK = 4'd8;
	localparam logic [3:0] S_SH_WR  = 4'd9;
	localparam logic [3:0] S_RM_END = 4'd10;
	localparam logic [3:0] S_L_RD   = 4'd11;
	localparam logic [3:0] S_L_EM   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       listing_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && (sts.in_func != FUNC_NONE)) begin
					ctl.take = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				ctl.load_fill = 1'b1;
				state_d       = S_DISP;
			end
			S_DISP: begin
				if (sts.func == FUNC_INSERT) begin
					state_d = S_INS;
				end else if (sts.empty) begin
					state_d = S_NOTF;
				end else begin
					state_d = S_RD;
				end
			end
			S_INS: begin
				if (sts.out_free) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = sts.full ? ST_FULL : ST_DONE;
					ctl.wr_ins      = !sts.full;
					ctl.fill_inc    = !sts.full;
					state_d         = S_IDLE;
				end
			end
			S_RD: begin
				ctl.rd_cur = 1'b1;
				state_d    = S_CMP;
			end
			S_CMP: begin
				if (sts.hit) begin
					state_d = (sts.func == FUNC_REMOVE) ? S_SH_CHK : S_FILL;
				end else if (sts.idx_last) begin
					state_d = S_NOTF;
				end else begin
					ctl.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_NOTF: begin
				if (sts.out_free) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = ST_NOT_FOUND;
					state_d         = S_IDLE;
				end
			end
			S_SH_CHK: begin
				if (sts.idx_last) begin
					state_d = S_RM_END;
				end else begin
					ctl.rd_next = 1'b1;
					state_d     = S_SH_WR;
				end
			end
			S_SH_WR: begin
				ctl.wr_shift = 1'b1;
				ctl.idx_inc  = 1'b1;
				state_d      = S_SH_CHK;
			end
			S_RM_END: begin
				if (sts.out_free) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = ST_DONE;
					ctl.fill_dec    = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_L_RD: begin
				ctl.rd_cur = 1'b1;
				state_d    = S_L_EM;
			end
			S_L_EM: begin
				if (sts.out_free) begin
					ctl.emit          = 1'b1;
					ctl.emit_status   = ST_DONE;
					ctl.emit_entry    = 1'b1;
					ctl.emit_last_idx = 1'b1;
					if (sts.idx_last) begin
						state_d = S_IDLE;
					end else begin
						ctl.idx_inc = 1'b1;
						state_d     = S_L_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// search hit: reload fill to rewind the index, then list from the head
		if ((state_q == S_FILL) && (sts.func == FUNC_SEARCH) && !sts.empty
				&& sts.hit && !sts.div_done && listing_q) begin
			state_d = S_L_RD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listing_q <= 1'b0;
		end else if (ctl.take) begin
			listing_q <= 1'b0;
		end else if ((state_q == S_CMP) && sts.hit) begin
			listing_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_stall = (state_q != S_IDLE);

endmodule

FILE: src/chained_hash_set_table.sv
// ----------------------------------------------------------------------------
// chained_hash_set_table
// Hash table of 31-bit keys with bounded separate chaining per bucket.
// ----------------------------------------------------------------------------
// Channels: cmd carries one item (func, key) on cmd_valid with cmd_stall low;
// rsp carries result items (status, bucket_index, entry_key, last) on
// rsp_valid with rsp_stall low. cfg_wr_en writes the bucket count at once.
// One item is worked on at a time; cmd_stall is high from acceptance until
// the item's last result is loaded into the result register. An item with
// the unused func code is taken and dropped.
// The modulo unit works through the key four bits a cycle, then the
// bucket's fill count is looked up and the function dispatched. Insert
// then loads its result and returns to idle for the next item. Remove and
// search compare the chain one entry at a time through the key memory's
// registered read port; a remove then moves each later entry down one
// place, and a found search rewinds to the head and lists every entry of
// the bucket. The worst case is a search that matches the last entry of a
// full chain.
// Reset clears all fill counts and sets the bucket count to 21; the key
// memory holds no reset and needs no clearing pass.
// A stalled receiver holds the result register; the block waits with the
// next result and takes no new item until its last result is registered.
// ----------------------------------------------------------------------------
module chained_hash_set_table
	import chst_pkg::*;
#(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
	parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [BCNT_W-1:0] cfg_wr_data,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_item_t         cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_item_t         rsp
);

	chst_cmd_t ctl;
	chst_sts_t sts;

	chst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	chst_dpath #(
		.MAX_BUCKETS (MAX_BUCKETS),
		.CHAIN_DEPTH (CHAIN_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.rsp         (rsp),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.ctl         (ctl),
		.sts         (sts)
	);

endmodule

FILE: src/chst_checker.sv
// ----------------------------------------------------------------------------
// chst_checker
// Port-level checks of the chained hash set table, bound to the top level.
// ----------------------------------------------------------------------------
module chst_checker
	import chst_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input cmd_item_t         cmd,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input rsp_item_t         rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_DONE) || (rsp.status == ST_FULL)
			|| (rsp.status == ST_NOT_FOUND))
		else $error("unknown status code");

	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DONE) |-> rsp.last && (rsp.entry_key == '0))
		else $error("failure result not single and empty");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && (cmd.func != FUNC_NONE) |=> cmd_stall)
		else $error("new item taken while one is at work");

endmodule

bind chained_hash_set_table chst_checker u_chst_checker (.*);
